/* hw/rtl/bhc_pkg.sv */
// ---------------------------------------------------------------------------
// bhc_pkg: shared types and constants for the baro/hygro compensation block
// Register indexes, datapath constants, divider geometry and the side-band
// record that travels through the pressure divider.
// ---------------------------------------------------------------------------
`default_nettype none

package bhc_pkg;

   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_TEMP_COEFFS     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESS_LOW       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESS_HIGH      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESS_NINE      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HUM_LOW         = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_HUM_HIGH        = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_HUM_PRESENT     = 3'd6;

   // Pressure divider: 64-bit magnitude quotient, four bits retired per stage.
   localparam int DIV_WIDTH  = 64;
   localparam int DIV_BITS   = 4;
   localparam int DIV_STAGES = DIV_WIDTH / DIV_BITS;
   localparam int DIV_DEN_W  = 31;

   localparam logic [31:0] T_ROUND     = 32'd128;
   localparam logic [33:0] P_OFFSET    = 34'd128000;
   localparam logic [63:0] P_SCALE     = 64'd3125;
   localparam logic [20:0] P_BASE      = 21'd1048576;
   localparam logic [63:0] P_HALF      = 64'h0000_8000_0000_0000;
   localparam logic [63:0] P_MAX       = 64'd2097151;
   localparam logic [31:0] H_OFFSET    = 32'd76800;
   localparam logic [31:0] H_CLAMP     = 32'd419430400;
   localparam logic [15:0] H_SKIP      = 16'h8000;
   localparam logic [31:0] H_Y_BIAS    = 32'd2097152;
   localparam logic [31:0] H_X_ROUND   = 32'd16384;
   localparam logic [31:0] H_Y_ROUND   = 32'd8192;
   localparam logic [31:0] H_H3_BIAS   = 32'd32768;

   typedef struct packed {
      logic        neg;
      logic        fault;
      logic [15:0] tc;
      logic [6:0]  hm;
   } bhc_side_type;

   function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned sh);
      return $signed(x) >>> sh;
   endfunction

   function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned sh);
      return $signed(x) >>> sh;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/bhc_div_pipe.sv */
// ---------------------------------------------------------------------------
// bhc_div_pipe: pipelined unsigned restoring divider
// Divides a 64-bit magnitude by a 31-bit magnitude, retiring DIV_BITS
// quotient bits in each register stage. A side record rides along.
// ---------------------------------------------------------------------------
`default_nettype none

module bhc_div_pipe import bhc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [DIV_WIDTH-1:0] in_dividend,
   input  logic [DIV_DEN_W-1:0] in_divisor,
   input  bhc_side_type         in_side,
   output logic                 out_valid,
   output logic [DIV_WIDTH-1:0] out_quotient,
   output bhc_side_type         out_side
);

   logic [DIV_STAGES-1:0] valid_ff;
   logic [DIV_WIDTH-1:0]  num_ff  [DIV_STAGES];
   logic [DIV_DEN_W-1:0]  rem_ff  [DIV_STAGES-1];
   logic [DIV_DEN_W-1:0]  den_ff  [DIV_STAGES-1];
   bhc_side_type          side_ff [DIV_STAGES];

   logic [DIV_STAGES-1:0] valid_src;
   logic [DIV_WIDTH-1:0]  num_src  [DIV_STAGES];
   logic [DIV_DEN_W-1:0]  rem_src  [DIV_STAGES];
   logic [DIV_DEN_W-1:0]  den_src  [DIV_STAGES];
   bhc_side_type          side_src [DIV_STAGES];

   logic [DIV_WIDTH-1:0]  num_in [DIV_STAGES];
   logic [DIV_DEN_W-1:0]  rem_in [DIV_STAGES];

   always_comb begin
      valid_src   = {valid_ff[DIV_STAGES-2:0], in_valid};
      num_src[0]  = in_dividend;
      rem_src[0]  = '0;
      den_src[0]  = in_divisor;
      side_src[0] = in_side;
      for (int k = 1; k < DIV_STAGES; k++) begin
         num_src[k]  = num_ff[k-1];
         rem_src[k]  = rem_ff[k-1];
         den_src[k]  = den_ff[k-1];
         side_src[k] = side_ff[k-1];
      end
   end

   // Each stage shifts in the next DIV_BITS dividend bits, subtracting whenever it fits;
   // quotient bits fill the low end of the shifting dividend word.
   always_comb begin
      logic [DIV_DEN_W:0]   trial;
      logic [DIV_WIDTH-1:0] num;
      logic [DIV_DEN_W-1:0] rem;
      for (int k = 0; k < DIV_STAGES; k++) begin
         num = num_src[k];
         rem = rem_src[k];
         for (int j = 0; j < DIV_BITS; j++) begin
            trial = {rem, num[DIV_WIDTH-1]};
            num   = {num[DIV_WIDTH-2:0], 1'b0};
            if (trial >= {1'b0, den_src[k]}) begin
               rem    = DIV_DEN_W'(trial - {1'b0, den_src[k]});
               num[0] = 1'b1;
            end else begin
               rem = trial[DIV_DEN_W-1:0];
            end
         end
         num_in[k] = num;
         rem_in[k] = rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_src;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            num_ff[k]  <= num_in[k];
            side_ff[k] <= side_src[k];
         end
         for (int k = 0; k < DIV_STAGES-1; k++) begin
            rem_ff[k] <= rem_in[k];
            den_ff[k] <= den_src[k];
         end
      end
   end

   assign out_valid    = valid_ff[DIV_STAGES-1];
   assign out_quotient = num_ff[DIV_STAGES-1];
   assign out_side     = side_ff[DIV_STAGES-1];

endmodule

`default_nettype wire

/* hw/rtl/baro_hygro_compensation.sv */
// ---------------------------------------------------------------------------
// baro_hygro_compensation: integer compensation of raw baro/hygro samples
// Turns one raw temperature/pressure/humidity sample set into centidegrees,
// pascals and percent relative humidity from packed calibration registers.
// ---------------------------------------------------------------------------
//
//   Channel | Ports           | Direction | Moves
//   --------+-----------------+-----------+--------------------------------
//   csr     | csr_valid/ready | in        | one register write per transaction
//   req     | req_valid/ready | in        | one raw sample set per transaction
//   rsp     | rsp_valid/ready | out       | one compensated result per transaction
//
// A new sample set is taken every cycle while the pipeline advances. The
// pipeline has ten stages of temperature, humidity and pressure arithmetic,
// sixteen divider stages that retire four quotient bits each, and five stages
// of pressure finishing. All stages advance together; when the result register
// is held by rsp_ready low, the whole pipeline holds and req_ready drops. Reset
// clears the valid bits and the calibration registers; csr_ready is always high.
// ---------------------------------------------------------------------------
`default_nettype none

module baro_hygro_compensation import bhc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]            csr_wdata,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [19:0]            req_raw_temperature,
   input  logic [19:0]            req_raw_pressure,
   input  logic [15:0]            req_raw_humidity,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [15:0]     rsp_temperature_centi,
   output logic [20:0]            rsp_pressure_pa,
   output logic [6:0]             rsp_humidity_pct,
   output logic                   rsp_pressure_fault
);

   // Calibration registers.
   logic [47:0] temp_coeffs_ff;
   logic [63:0] press_low_ff;
   logic [63:0] press_high_ff;
   logic [15:0] press_nine_ff;
   logic [31:0] hum_low_ff;
   logic [39:0] hum_high_ff;
   logic        hum_present_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_coeffs_ff <= '0;
         press_low_ff   <= '0;
         press_high_ff  <= '0;
         press_nine_ff  <= '0;
         hum_low_ff     <= '0;
         hum_high_ff    <= '0;
         hum_present_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TEMP_COEFFS: temp_coeffs_ff <= csr_wdata[47:0];
            CSR_PRESS_LOW:   press_low_ff   <= csr_wdata;
            CSR_PRESS_HIGH:  press_high_ff  <= csr_wdata;
            CSR_PRESS_NINE:  press_nine_ff  <= csr_wdata[15:0];
            CSR_HUM_LOW:     hum_low_ff     <= csr_wdata[31:0];
            CSR_HUM_HIGH:    hum_high_ff    <= csr_wdata[39:0];
            CSR_HUM_PRESENT: hum_present_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // Coefficient fields.
   logic [15:0]        t1;
   logic [31:0]        t2_32, t3_32;
   logic [15:0]        p1;
   logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
   logic [31:0]        h1_32, h2_32, h3_32, h4_32, h5_32, h6_32;

   always_comb begin
      t1    = temp_coeffs_ff[15:0];
      t2_32 = {{16{temp_coeffs_ff[31]}}, temp_coeffs_ff[31:16]};
      t3_32 = {{16{temp_coeffs_ff[47]}}, temp_coeffs_ff[47:32]};
      p1    = press_low_ff[15:0];
      p2    = press_low_ff[31:16];
      p3    = press_low_ff[47:32];
      p4    = press_low_ff[63:48];
      p5    = press_high_ff[15:0];
      p6    = press_high_ff[31:16];
      p7    = press_high_ff[47:32];
      p8    = press_high_ff[63:48];
      p9    = press_nine_ff;
      h1_32 = {24'd0, hum_low_ff[7:0]};
      h2_32 = {{16{hum_low_ff[23]}}, hum_low_ff[23:8]};
      h3_32 = {24'd0, hum_low_ff[31:24]};
      h4_32 = {{16{hum_high_ff[15]}}, hum_high_ff[15:0]};
      h5_32 = {{16{hum_high_ff[31]}}, hum_high_ff[31:16]};
      h6_32 = {{24{hum_high_ff[39]}}, hum_high_ff[39:32]};
   end

   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   logic [9:0] pre_valid_ff;
   logic [4:0] post_valid_ff;

   // ---------------- Stage 1: temperature offsets and products.
   logic [31:0] adc_t32, ta, tb;
   logic [31:0] s1_m1_in, s1_bb_in, s1_m1_ff, s1_bb_ff;
   logic [19:0] s1_adcp_ff;
   logic [15:0] s1_adch_ff;

   always_comb begin
      adc_t32  = {12'd0, req_raw_temperature};
      ta       = (adc_t32 >> 3) - {15'd0, t1, 1'b0};
      tb       = (adc_t32 >> 4) - {16'd0, t1};
      s1_m1_in = ta * t2_32;
      s1_bb_in = tb * tb;
   end

   // ---------------- Stage 2.
   logic [31:0] s2_v1_in, s2_m3_in, s2_v1_ff, s2_m3_ff;
   logic [19:0] s2_adcp_ff;
   logic [15:0] s2_adch_ff;

   always_comb begin
      s2_v1_in = asr32(s1_m1_ff, 11);
      s2_m3_in = asr32(s1_bb_ff, 12) * t3_32;
   end

   // ---------------- Stage 3: fine temperature.
   logic [31:0] s3_tf_in, s3_tf_ff;
   logic [19:0] s3_adcp_ff;
   logic [15:0] s3_adch_ff;

   assign s3_tf_in = s2_v1_ff + asr32(s2_m3_ff, 14);

   // ---------------- Stage 4: centidegrees, pressure offset, humidity start.
   logic [31:0] t5, tsh, hv;
   logic [15:0] s4_tc_in, s4_tc_ff;
   logic [33:0] s4_qs_in, s4_qs_ff;
   logic [31:0] s4_hx5_in, s4_hv6_in, s4_hv3_in, s4_xpre_in;
   logic [31:0] s4_hx5_ff, s4_hv6_ff, s4_hv3_ff, s4_xpre_ff;
   logic        s4_hen_in, s4_hen_ff;
   logic [19:0] s4_adcp_ff;

   always_comb begin
      t5  = (s3_tf_ff << 2) + s3_tf_ff + T_ROUND;
      tsh = asr32(t5, 8);
      if ($signed(tsh) > 32'sd32767) begin
         s4_tc_in = 16'h7fff;
      end else if ($signed(tsh) < -32'sd32768) begin
         s4_tc_in = 16'h8000;
      end else begin
         s4_tc_in = tsh[15:0];
      end
      s4_qs_in   = {{2{s3_tf_ff[31]}}, s3_tf_ff} - P_OFFSET;
      hv         = s3_tf_ff - H_OFFSET;
      s4_hx5_in  = h5_32 * hv;
      s4_hv6_in  = hv * h6_32;
      s4_hv3_in  = hv * h3_32;
      s4_xpre_in = ({16'd0, s3_adch_ff} << 14) - (h4_32 << 20) + H_X_ROUND;
      s4_hen_in  = hum_present_ff && (s3_adch_ff != H_SKIP);
   end

   // ---------------- Stage 5.
   logic signed [67:0] sq_full;
   logic signed [49:0] m5_full, m2_full;
   logic [63:0] s5_sq_ff;
   logic [49:0] s5_m5_ff, s5_m2_ff;
   logic [31:0] s5_hx_in, s5_y1_in, s5_hx_ff, s5_y1_ff;
   logic [15:0] s5_tc_ff;
   logic        s5_hen_ff;
   logic [19:0] s5_adcp_ff;

   always_comb begin
      sq_full  = $signed(s4_qs_ff) * $signed(s4_qs_ff);
      m5_full  = $signed(s4_qs_ff) * p5;
      m2_full  = $signed(s4_qs_ff) * p2;
      s5_hx_in = asr32(s4_xpre_ff - s4_hx5_ff, 15);
      s5_y1_in = asr32(s4_hv6_ff, 10) * (asr32(s4_hv3_ff, 11) + H_H3_BIAS);
   end

   // ---------------- Stage 6.
   logic signed [79:0] q2a_full, m3p_full;
   logic [31:0] hy;
   logic [63:0] s6_q2a_ff, s6_m3p_ff;
   logic [49:0] s6_m5_ff, s6_m2_ff;
   logic [31:0] s6_my_in, s6_my_ff, s6_hx_ff;
   logic [15:0] s6_tc_ff;
   logic        s6_hen_ff;
   logic [19:0] s6_adcp_ff;

   always_comb begin
      q2a_full = $signed(s5_sq_ff) * p6;
      m3p_full = $signed(s5_sq_ff) * p3;
      hy       = asr32(s5_y1_ff, 10) + H_Y_BIAS;
      s6_my_in = hy * h2_32 + H_Y_ROUND;
   end

   // ---------------- Stage 7.
   logic [63:0] s7_q2_in, s7_t47_in, s7_q2_ff, s7_t47_ff;
   logic [31:0] s7_hw_in, s7_hw_ff;
   logic [15:0] s7_tc_ff;
   logic        s7_hen_ff;
   logic [19:0] s7_adcp_ff;

   always_comb begin
      s7_q2_in  = s6_q2a_ff + ({{14{s6_m5_ff[49]}}, s6_m5_ff} << 17)
                + ({{48{p4[15]}}, p4} << 35);
      s7_t47_in = P_HALF + asr64(s6_m3p_ff, 8) + ({{14{s6_m2_ff[49]}}, s6_m2_ff} << 12);
      s7_hw_in  = s6_hx_ff * asr32(s6_my_ff, 14);
   end

   // ---------------- Stage 8: pressure divisor.
   logic [79:0] dprod;
   logic [30:0] s8_d_ff;
   logic [20:0] s8_pn_in, s8_pn_ff;
   logic [63:0] s8_q2_ff;
   logic [31:0] s8_hsq_in, s8_hsq_ff, s8_hw_ff, hws;
   logic [15:0] s8_tc_ff;
   logic        s8_hen_ff;

   always_comb begin
      dprod     = s7_t47_ff * p1;
      s8_pn_in  = P_BASE - {1'b0, s7_adcp_ff};
      hws       = asr32(s7_hw_ff, 15);
      s8_hsq_in = hws * hws;
   end

   // ---------------- Stage 9: dividend.
   logic [63:0] nbase, s9_n_in, s9_n_ff;
   logic [30:0] s9_d_ff;
   logic [31:0] s9_hr_in, s9_hr_ff, s9_hw_ff;
   logic [15:0] s9_tc_ff;
   logic        s9_hen_ff;

   always_comb begin
      nbase    = ({43'd0, s8_pn_ff} << 31) - s8_q2_ff;
      s9_n_in  = nbase * P_SCALE;
      s9_hr_in = asr32(s8_hsq_ff, 7) * h1_32;
   end

   // ---------------- Stage 10: magnitudes, signs and the humidity result.
   logic [31:0]  hw2, hclamp;
   logic [63:0]  s10_mn_in, s10_mn_ff;
   logic [30:0]  s10_md_in, s10_md_ff;
   bhc_side_type s10_side_in, s10_side_ff;

   always_comb begin
      s10_mn_in = s9_n_ff[63] ? (64'd0 - s9_n_ff) : s9_n_ff;
      s10_md_in = s9_d_ff[30] ? (31'd0 - s9_d_ff) : s9_d_ff;
      hw2       = s9_hw_ff - asr32(s9_hr_ff, 4);
      if (hw2[31]) begin
         hclamp = '0;
      end else if (hw2 > H_CLAMP) begin
         hclamp = H_CLAMP;
      end else begin
         hclamp = hw2;
      end
      s10_side_in.neg   = s9_n_ff[63] ^ s9_d_ff[30];
      s10_side_in.fault = (s9_d_ff == '0);
      s10_side_in.tc    = s9_tc_ff;
      s10_side_in.hm    = s9_hen_ff ? hclamp[28:22] : 7'd0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_m1_ff    <= s1_m1_in;
         s1_bb_ff    <= s1_bb_in;
         s1_adcp_ff  <= req_raw_pressure;
         s1_adch_ff  <= req_raw_humidity;
         s2_v1_ff    <= s2_v1_in;
         s2_m3_ff    <= s2_m3_in;
         s2_adcp_ff  <= s1_adcp_ff;
         s2_adch_ff  <= s1_adch_ff;
         s3_tf_ff    <= s3_tf_in;
         s3_adcp_ff  <= s2_adcp_ff;
         s3_adch_ff  <= s2_adch_ff;
         s4_tc_ff    <= s4_tc_in;
         s4_qs_ff    <= s4_qs_in;
         s4_hx5_ff   <= s4_hx5_in;
         s4_hv6_ff   <= s4_hv6_in;
         s4_hv3_ff   <= s4_hv3_in;
         s4_xpre_ff  <= s4_xpre_in;
         s4_hen_ff   <= s4_hen_in;
         s4_adcp_ff  <= s3_adcp_ff;
         s5_sq_ff    <= sq_full[63:0];
         s5_m5_ff    <= m5_full;
         s5_m2_ff    <= m2_full;
         s5_hx_ff    <= s5_hx_in;
         s5_y1_ff    <= s5_y1_in;
         s5_tc_ff    <= s4_tc_ff;
         s5_hen_ff   <= s4_hen_ff;
         s5_adcp_ff  <= s4_adcp_ff;
         s6_q2a_ff   <= q2a_full[63:0];
         s6_m3p_ff   <= m3p_full[63:0];
         s6_m5_ff    <= s5_m5_ff;
         s6_m2_ff    <= s5_m2_ff;
         s6_my_ff    <= s6_my_in;
         s6_hx_ff    <= s5_hx_ff;
         s6_tc_ff    <= s5_tc_ff;
         s6_hen_ff   <= s5_hen_ff;
         s6_adcp_ff  <= s5_adcp_ff;
         s7_q2_ff    <= s7_q2_in;
         s7_t47_ff   <= s7_t47_in;
         s7_hw_ff    <= s7_hw_in;
         s7_tc_ff    <= s6_tc_ff;
         s7_hen_ff   <= s6_hen_ff;
         s7_adcp_ff  <= s6_adcp_ff;
         s8_d_ff     <= dprod[63:33];
         s8_pn_ff    <= s8_pn_in;
         s8_q2_ff    <= s7_q2_ff;
         s8_hsq_ff   <= s8_hsq_in;
         s8_hw_ff    <= s7_hw_ff;
         s8_tc_ff    <= s7_tc_ff;
         s8_hen_ff   <= s7_hen_ff;
         s9_n_ff     <= s9_n_in;
         s9_d_ff     <= s8_d_ff;
         s9_hr_ff    <= s9_hr_in;
         s9_hw_ff    <= s8_hw_ff;
         s9_tc_ff    <= s8_tc_ff;
         s9_hen_ff   <= s8_hen_ff;
         s10_mn_ff   <= s10_mn_in;
         s10_md_ff   <= s10_md_in;
         s10_side_ff <= s10_side_in;
      end
   end

   // ---------------- Divider.
   logic         div_valid;
   logic [63:0]  div_q;
   bhc_side_type div_side;

   bhc_div_pipe u_div (
      .clock        (clock),
      .reset        (reset),
      .en           (adv),
      .in_valid     (pre_valid_ff[9]),
      .in_dividend  (s10_mn_ff),
      .in_divisor   (s10_md_ff),
      .in_side      (s10_side_ff),
      .out_valid    (div_valid),
      .out_quotient (div_q),
      .out_side     (div_side)
   );

   // ---------------- Stage 11: signed quotient.
   logic [63:0]  s11_p_in, s11_p_ff;
   bhc_side_type s11_side_ff;

   assign s11_p_in = div_side.neg ? (64'd0 - div_q) : div_q;

   // ---------------- Stage 12: P9 and P8 products.
   logic signed [66:0] x_full;
   logic signed [79:0] p8p_full;
   logic [63:0]  s12_x_ff, s12_pp8_ff, s12_p_ff;
   bhc_side_type s12_side_ff;

   always_comb begin
      x_full   = p9 * $signed(s11_p_ff[63:13]);
      p8p_full = p8 * $signed(s11_p_ff);
   end

   // ---------------- Stage 13: partial products of the square term.
   logic [63:0]  a64, s13_lo_in, s13_lo_ff, s13_pp8_ff, s13_p_ff;
   logic [31:0]  s13_mx_in, s13_mx_ff;
   bhc_side_type s13_side_ff;

   always_comb begin
      a64       = {{13{s12_p_ff[63]}}, s12_p_ff[63:13]};
      s13_lo_in = s12_x_ff[31:0] * a64[31:0];
      s13_mx_in = s12_x_ff[31:0] * a64[63:32] + s12_x_ff[63:32] * a64[31:0];
   end

   // ---------------- Stage 14: correction sum.
   logic [63:0]  sqterm, s14_sum_in, s14_sum_ff;
   bhc_side_type s14_side_ff;

   always_comb begin
      sqterm     = s13_lo_ff + {s13_mx_ff, 32'd0};
      s14_sum_in = s13_p_ff + asr64(sqterm, 25) + asr64(s13_pp8_ff, 19);
   end

   // ---------------- Stage 15: scaling, saturation and the result register.
   logic [63:0] ps, pf;
   logic [20:0] out_pa_in, out_pa_ff;
   logic [15:0] out_tc_ff;
   logic [6:0]  out_hm_ff;
   logic        out_fault_ff;

   always_comb begin
      ps = asr64(s14_sum_ff, 8) + ({{48{p7[15]}}, p7} << 4);
      pf = asr64(ps, 8);
      if (s14_side_ff.fault || pf[63]) begin
         out_pa_in = '0;
      end else if (pf > P_MAX) begin
         out_pa_in = P_MAX[20:0];
      end else begin
         out_pa_in = pf[20:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s11_p_ff     <= s11_p_in;
         s11_side_ff  <= div_side;
         s12_x_ff     <= x_full[63:0];
         s12_pp8_ff   <= p8p_full[63:0];
         s12_p_ff     <= s11_p_ff;
         s12_side_ff  <= s11_side_ff;
         s13_lo_ff    <= s13_lo_in;
         s13_mx_ff    <= s13_mx_in;
         s13_pp8_ff   <= s12_pp8_ff;
         s13_p_ff     <= s12_p_ff;
         s13_side_ff  <= s12_side_ff;
         s14_sum_ff   <= s14_sum_in;
         s14_side_ff  <= s13_side_ff;
         out_pa_ff    <= out_pa_in;
         out_tc_ff    <= s14_side_ff.tc;
         out_hm_ff    <= s14_side_ff.hm;
         out_fault_ff <= s14_side_ff.fault;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff  <= '0;
         post_valid_ff <= '0;
      end else if (adv) begin
         pre_valid_ff  <= {pre_valid_ff[8:0], req_valid};
         post_valid_ff <= {post_valid_ff[3:0], div_valid};
      end
   end

   assign rsp_valid             = post_valid_ff[4];
   assign rsp_temperature_centi = out_tc_ff;
   assign rsp_pressure_pa       = out_pa_ff;
   assign rsp_humidity_pct      = out_hm_ff;
   assign rsp_pressure_fault    = out_fault_ff;

endmodule

`default_nettype wire

/* hw/rtl/bhc_checker.sv */
// ---------------------------------------------------------------------------
// bhc_checker: port-level checks for the compensation block
// Watches the top-level ports for result handshake and result-range rules.
// ---------------------------------------------------------------------------
`default_nettype none

module bhc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_temperature_centi,
   input logic [20:0]        rsp_pressure_pa,
   input logic [6:0]         rsp_humidity_pct,
   input logic               rsp_pressure_fault
);

   // A pending result stays offered until the transaction completes.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before its transaction completed");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_temperature_centi) &&
      $stable(rsp_pressure_pa) && $stable(rsp_humidity_pct) &&
      $stable(rsp_pressure_fault))
      else $error("stalled result changed");

   // The pipeline only holds input when the result register is blocked.
   a_req_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while no result is pending");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pressure_fault |-> rsp_pressure_pa == 21'd0)
      else $error("pressure fault with nonzero pressure");

   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_humidity_pct <= 7'd100)
      else $error("humidity above full scale");

endmodule

bind baro_hygro_compensation bhc_checker u_bhc_checker (.*);

`default_nettype wire
